[hw/rtl/sha_pkg.sv]
// Shared types and constants for the SHA-256 hash engine.
// Holds the controller/datapath command and status structs, byte select codes
// and the FIPS 180-4 constant tables. Depends on nothing.
package sha_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;

    // Source of the byte shifted into the block register.
    typedef logic [1:0] byte_sel_t;
    localparam byte_sel_t SEL_IN   = 2'd0;
    localparam byte_sel_t SEL_PAD  = 2'd1;
    localparam byte_sel_t SEL_ZERO = 2'd2;
    localparam byte_sel_t SEL_LEN  = 2'd3;

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [5:0] FILL_LAST    = 6'd63;
    localparam logic [5:0] FILL_PRE_LEN = 6'd55;
    localparam logic [5:0] ROUND_LAST   = 6'd63;
    localparam logic [2:0] WORD_LAST    = 3'd7;

    typedef struct packed {
        logic      shift_en;
        byte_sel_t byte_sel;
        logic      load_work;
        logic      round_en;
        logic [5:0] round_idx;
        logic      fold;
        logic      reinit;
        logic [2:0] out_idx;
    } sha_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_pre_len;
    } sha_stat_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

[hw/rtl/sha_if.sv]
// Valid/ready channel interfaces for the SHA-256 hash engine.
// sha_in_if carries message words, sha_out_if carries digest words.
// Depends on nothing.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;

    modport source (output valid, data_byte, byte_valid, last_byte, input ready);
    modport sink   (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

[hw/rtl/sha256_hash_engine_core.sv]
// Top level of the SHA-256 hash engine: joins controller and datapath to the
// message and digest channels. Depends on sha_pkg, sha_if, sha_ctrl, sha_dp.
//
//  Channel | Dir | Payload                                 | Words per message
//  --------+-----+-----------------------------------------+------------------
//  msg     | in  | data_byte[7:0], byte_valid, last_byte   | any, last one flagged
//  digest  | out | digest_word[31:0], word_index[2:0], last_word | 8
//
// A word without a message byte shifts nothing in. The word that completes a
// 64-byte block is followed by a busy spell: the working variables are loaded,
// 64 rounds run (one per cycle through a single round unit) and the result is
// folded into the chaining state. The last word starts padding, shifted in one
// byte per cycle, with one or two compressions, before eight digest words.
// rst_n clears control state asynchronously and restores the initial hash.
// The digest channel holds its word while ready is low; no input is taken then.
module sha256_hash_engine_core (
    input  logic             clk,
    input  logic             rst_n,
    sha_in_if.sink           msg,
    sha_out_if.source        digest
);

    sha_pkg::sha_cmd_t  cmd;
    sha_pkg::sha_stat_t stat;
    logic               in_ready;
    logic               out_valid;
    logic [31:0]        digest_word;

    // The controller decides every step; the datapath only executes commands
    // and reports the block fill position.
    sha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (msg.valid),
        .byte_valid (msg.byte_valid),
        .last_byte  (msg.last_byte),
        .out_ready  (digest.ready),
        .stat       (stat),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .cmd        (cmd)
    );

    sha_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (msg.data_byte),
        .stat        (stat),
        .digest_word (digest_word)
    );

    // Digest words are read straight from the chaining-state registers, which
    // do not change while output is pending, so a stalled word stays stable.
    assign msg.ready          = in_ready;
    assign digest.valid       = out_valid;
    assign digest.digest_word = digest_word;
    assign digest.word_index  = cmd.out_idx;
    assign digest.last_word   = (cmd.out_idx == sha_pkg::WORD_LAST);

endmodule

[hw/rtl/sha_dp.sv]
// Datapath of the SHA-256 hash engine: block shift register, counters,
// chaining state, working variables and the round logic.
// Depends on sha_pkg.
module sha_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::sha_cmd_t cmd,
    input  logic [7:0]        data_byte,
    output sha_pkg::sha_stat_t stat,
    output logic [31:0]       digest_word
);

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
        rotr = (v >> s) | (v << (32 - s));
    endfunction

    // The block register holds 64 bytes, oldest byte in the top bits. During
    // the rounds it doubles as the 16-word message schedule window.
    logic [511:0] blk_reg;
    logic [5:0]   fill_reg;
    logic [60:0]  bytes_reg;
    logic [31:0]  hash_reg [8];
    logic [31:0]  work_reg [8];

    logic [63:0]  len_bits;
    logic [63:0]  len_shift;
    logic [7:0]   shift_byte;
    logic [31:0]  w0, w1, w9, w14;
    logic [31:0]  ssig0, ssig1, new_w;
    logic [31:0]  bsig0, bsig1, ch, maj, t1, t2;

    assign len_bits  = {bytes_reg, 3'b000};
    assign len_shift = len_bits << {fill_reg[2:0], 3'b000};

    always_comb
    begin
        case (cmd.byte_sel)
            sha_pkg::SEL_IN:   shift_byte = data_byte;
            sha_pkg::SEL_PAD:  shift_byte = sha_pkg::PAD_BYTE;
            sha_pkg::SEL_LEN:  shift_byte = len_shift[63:56];
            default:           shift_byte = 8'h00;
        endcase
    end

    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];

    assign ssig0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    assign ssig1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    assign new_w = ssig1 + w9 + ssig0 + w0;

    assign bsig1 = rotr(work_reg[4], 6) ^ rotr(work_reg[4], 11) ^ rotr(work_reg[4], 25);
    assign bsig0 = rotr(work_reg[0], 2) ^ rotr(work_reg[0], 13) ^ rotr(work_reg[0], 22);
    assign ch    = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj   = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]);
    assign t1    = work_reg[7] + bsig1 + ch + sha_pkg::ROUND_K[cmd.round_idx] + w0;
    assign t2    = bsig0 + maj;

    always_ff @(posedge clk)
    begin
        if (cmd.shift_en)
        begin
            blk_reg <= {blk_reg[503:0], shift_byte};
        end
        else if (cmd.round_en)
        begin
            blk_reg <= {blk_reg[479:0], new_w};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= hash_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            bytes_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha_pkg::INIT_HASH[i];
            end
        end
        else if (cmd.reinit)
        begin
            fill_reg  <= '0;
            bytes_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha_pkg::INIT_HASH[i];
            end
        end
        else
        begin
            if (cmd.shift_en)
            begin
                fill_reg <= fill_reg + 6'd1;
                if (cmd.byte_sel == sha_pkg::SEL_IN)
                begin
                    bytes_reg <= bytes_reg + 61'd1;
                end
            end
            if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + work_reg[i];
                end
            end
        end
    end

    assign stat.fill_last    = (fill_reg == sha_pkg::FILL_LAST);
    assign stat.fill_pre_len = (fill_reg == sha_pkg::FILL_PRE_LEN);
    assign digest_word       = hash_reg[cmd.out_idx];

endmodule

[hw/rtl/sha_ctrl.sv]
// Controller of the SHA-256 hash engine: sequences byte intake, padding,
// the 64 compression rounds and digest output. Depends on sha_pkg.
module sha_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               byte_valid,
    input  logic               last_byte,
    input  logic               out_ready,
    input  sha_pkg::sha_stat_t stat,
    output logic               in_ready,
    output logic               out_valid,
    output sha_pkg::sha_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_FOLD  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [2:0] idx_reg, idx_next;
    logic       pad_mode_reg, pad_mode_next;
    logic       pad_first_reg, pad_first_next;
    logic       len_phase_reg, len_phase_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pad_mode_next  = pad_mode_reg;
        pad_first_next = pad_first_reg;
        len_phase_next = len_phase_reg;
        cmd            = '0;
        cmd.round_idx  = cnt_reg;
        cmd.out_idx    = idx_reg;
        in_ready       = 1'b0;
        out_valid      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (byte_valid)
                    begin
                        cmd.shift_en = 1'b1;
                        cmd.byte_sel = sha_pkg::SEL_IN;
                    end
                    if (byte_valid && stat.fill_last)
                    begin
                        state_next     = S_INIT;
                        pad_mode_next  = last_byte;
                        pad_first_next = last_byte;
                    end
                    else if (last_byte)
                    begin
                        state_next     = S_PAD;
                        pad_mode_next  = 1'b1;
                        pad_first_next = 1'b1;
                    end
                end
            end
            S_PAD:
            begin
                cmd.shift_en = 1'b1;
                if (pad_first_reg)
                begin
                    cmd.byte_sel = sha_pkg::SEL_PAD;
                end
                else if (len_phase_reg)
                begin
                    cmd.byte_sel = sha_pkg::SEL_LEN;
                end
                else
                begin
                    cmd.byte_sel = sha_pkg::SEL_ZERO;
                end
                pad_first_next = 1'b0;
                if (!len_phase_reg && stat.fill_pre_len)
                begin
                    len_phase_next = 1'b1;
                end
                if (stat.fill_last)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.load_work = 1'b1;
                cnt_next      = '0;
                state_next    = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == sha_pkg::ROUND_LAST)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                if (!pad_mode_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (len_phase_reg)
                begin
                    state_next = S_OUT;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = S_PAD;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha_pkg::WORD_LAST)
                    begin
                        cmd.reinit     = 1'b1;
                        pad_mode_next  = 1'b0;
                        len_phase_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pad_mode_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            len_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            pad_mode_reg  <= pad_mode_next;
            pad_first_reg <= pad_first_next;
            len_phase_reg <= len_phase_next;
        end
    end

    // The last round always hands over to the chaining-state update.
    a_round_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && cnt_reg == sha_pkg::ROUND_LAST) |=> (state_reg == S_FOLD))
        else $error("round sequence did not end in fold");

    // Once the length bytes are folded in, the digest must be presented.
    a_fold_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FOLD && pad_mode_reg && len_phase_reg) |=> (out_valid && idx_reg == 3'd0))
        else $error("digest output did not start after the final block");

    // The final digest word returns the engine to idle with padding state cleared.
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && idx_reg == sha_pkg::WORD_LAST)
        |=> (state_reg == S_IDLE && !pad_mode_reg && !len_phase_reg))
        else $error("engine did not return to idle after the last digest word");

    // Input and output are never open in the same cycle.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output handshakes open together");

endmodule
